### design/multi_channel_input_debouncer_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multi-channel input debouncer
// Shared concurrent property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_INPUT_DEBOUNCER_TOP_DEFINES_SVH
`define MULTI_CHANNEL_INPUT_DEBOUNCER_TOP_DEFINES_SVH

// same-cycle implication, checked on the rising edge, off during reset
`define MCID_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on the rising edge, off during reset
`define MCID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/mcid_pkg.sv
// ----------------------------------------------------------------------------
// mcid_pkg
// Constants and codes shared by the debouncer and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package mcid_pkg;

   // number of debounced input lines (1 to 16)
   localparam int CHANNELS   = 10;
   localparam int CHAN_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // fixed field widths
   localparam int CHAN_W    = 4;
   localparam int COUNT_W   = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 8;
   localparam int REQ_DAT_W = 8;
   localparam int RSP_DAT_W = 8;
   localparam int RSP_USR_W = 2;

   typedef logic [CHAN_W-1:0]  chan_type;
   typedef logic [COUNT_W-1:0] count_type;

   // event codes carried on rsp_tuser
   typedef enum logic [RSP_USR_W-1:0] {
      KIND_NONE    = 2'd0,
      KIND_ASSERT  = 2'd1,
      KIND_RELEASE = 2'd2
   } kind_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POWER_BUTTON = 3'd0,
      CSR_ADAPTER      = 3'd1,
      CSR_BATTERY      = 3'd2,
      CSR_LID          = 3'd3,
      CSR_KEY          = 3'd4
   } csr_idx_type;

   // dedicated channel numbers; everything else uses the key time
   localparam chan_type CH_POWER_A = 4'd0;
   localparam chan_type CH_ADAPTER = 4'd1;
   localparam chan_type CH_BATTERY = 4'd2;
   localparam chan_type CH_LID     = 4'd3;
   localparam chan_type CH_POWER_B = 4'd4;

endpackage

`default_nettype wire

### design/multi_channel_input_debouncer_top.sv
// ----------------------------------------------------------------------------
// multi_channel_input_debouncer_top
// Counter-based debouncer for up to sixteen input lines, one sample per word.
// ----------------------------------------------------------------------------
//  channel  dir  data                                  user
//  req_     in   [3:0] channel, [4] raw_level          -
//  rsp_     out  [3:0] event_channel, [4] stable_level [1:0] event_kind
//  csr_     in   index, data (8 bit debounce times)    -
//
//  One word per cycle sustained while rsp_tready stays high; each word is
//  taken into the input register, then moves into the result register,
//  which drives rsp valid.
//  The per-channel level and countdown are updated in the same cycle the
//  result register loads, so back-to-back words on one channel see fresh state.
//  A stalled rsp_ holds the result and the input register; req_tready drops
//  only when both are full. Synchronous reset clears all channel state.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_input_debouncer_top
   import mcid_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // input samples
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [REQ_DAT_W-1:0] req_tdata,   // [3:0] channel, [4] raw_level
   // debounce results
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [RSP_DAT_W-1:0]      rsp_tdata,   // [3:0] event_channel, [4] stable_level
   output logic [RSP_USR_W-1:0]      rsp_tuser,   // [1:0] event_kind
   // configuration writes
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata
);

   // configuration registers
   count_type power_time_ff, adapter_time_ff, battery_time_ff, lid_time_ff, key_time_ff;

   // input register
   logic     in_valid_ff;
   chan_type in_chan_ff;
   logic     in_raw_ff;

   // result register
   logic     rsp_valid_ff;
   chan_type rsp_chan_ff;
   kind_type rsp_kind_ff;
   logic     rsp_level_ff;

   // per-channel state
   logic      level_ff [CHANNELS];
   count_type count_ff [CHANNELS];
   logic      level_in [CHANNELS];
   count_type count_in [CHANNELS];

   // datapath
   logic                  rsp_free;
   logic                  advance;
   logic                  in_range;
   logic [CHAN_IDX_W-1:0] idx;
   logic                  cur_level;
   count_type             cur_count;
   count_type             load_time;
   count_type             new_count;
   logic                  fire;
   kind_type              kind_in;
   logic                  level_out;

   // configuration write; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         power_time_ff   <= '0;
         adapter_time_ff <= '0;
         battery_time_ff <= '0;
         lid_time_ff     <= '0;
         key_time_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_POWER_BUTTON: power_time_ff   <= csr_wdata;
            CSR_ADAPTER:      adapter_time_ff <= csr_wdata;
            CSR_BATTERY:      battery_time_ff <= csr_wdata;
            CSR_LID:          lid_time_ff     <= csr_wdata;
            CSR_KEY:          key_time_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // handshake: move a word forward when the result register can take it
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && rsp_free;
   assign req_tready = !in_valid_ff || rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_chan_ff <= req_tdata[CHAN_W-1:0];
         in_raw_ff  <= req_tdata[CHAN_W];
      end
   end

   // select the channel's state
   assign in_range  = {1'b0, in_chan_ff} < (CHAN_W+1)'(CHANNELS);
   assign idx       = in_chan_ff[CHAN_IDX_W-1:0];
   assign cur_level = in_range ? level_ff[idx] : 1'b0;
   assign cur_count = in_range ? count_ff[idx] : '0;

   // debounce time for this channel
   always_comb begin
      unique case (in_chan_ff)
         CH_POWER_A, CH_POWER_B: load_time = power_time_ff;
         CH_ADAPTER:             load_time = adapter_time_ff;
         CH_BATTERY:             load_time = battery_time_ff;
         CH_LID:                 load_time = lid_time_ff;
         default:                load_time = key_time_ff;
      endcase
   end

   // countdown: if raw differs load when idle, else count down, fire at zero; else clear
   always_comb begin
      new_count = '0;
      fire      = 1'b0;
      if (in_raw_ff != cur_level) begin
         if (cur_count == '0) begin
            new_count = load_time;
         end else begin
            new_count = cur_count - 1'b1;
            fire      = (cur_count == count_type'(1));
         end
      end
   end

   always_comb begin
      kind_in   = KIND_NONE;
      level_out = cur_level;
      if (in_range && fire) begin
         kind_in   = in_raw_ff ? KIND_ASSERT : KIND_RELEASE;
         level_out = in_raw_ff;
      end
   end

   // write back the selected channel only
   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         level_in[i] = level_ff[i];
         count_in[i] = count_ff[i];
         if (advance && in_range && (idx == CHAN_IDX_W'(i))) begin
            level_in[i] = level_out;
            count_in[i] = new_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            level_ff[i] <= 1'b0;
            count_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < CHANNELS; i++) begin
            level_ff[i] <= level_in[i];
            count_ff[i] <= count_in[i];
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_chan_ff  <= in_chan_ff;
         rsp_kind_ff  <= kind_in;
         rsp_level_ff <= level_out;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DAT_W-CHAN_W-1)'(0), rsp_level_ff, rsp_chan_ff};
   assign rsp_tuser  = rsp_kind_ff;

endmodule

`default_nettype wire

### design/mcid_checker.sv
// ----------------------------------------------------------------------------
// mcid_checker
// Port-level checks on the debouncer results, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_channel_input_debouncer_top_defines.svh"

module mcid_checker
   import mcid_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_tvalid,
   input wire logic                 rsp_tready,
   input wire logic [RSP_DAT_W-1:0] rsp_tdata,
   input wire logic [RSP_USR_W-1:0] rsp_tuser
);

   logic chan_bad;

   assign chan_bad = {1'b0, rsp_tdata[CHAN_W-1:0]} >= (CHAN_W+1)'(CHANNELS);

   // only defined event codes leave the block
   `MCID_ASSERT_NOW(a_kind_code, clock, reset, rsp_tvalid,
      rsp_tuser == KIND_NONE || rsp_tuser == KIND_ASSERT || rsp_tuser == KIND_RELEASE,
      "undefined event kind")

   // an event reports the level the channel just moved to
   `MCID_ASSERT_NOW(a_event_level, clock, reset,
      rsp_tvalid && (rsp_tuser != KIND_NONE),
      rsp_tdata[CHAN_W] == (rsp_tuser == KIND_ASSERT),
      "event kind disagrees with stable level")

   // samples for missing channels give no event and a low level
   `MCID_ASSERT_NOW(a_bad_channel, clock, reset, rsp_tvalid && chan_bad,
      (rsp_tuser == KIND_NONE) && !rsp_tdata[CHAN_W],
      "unused channel produced an event or a level")

   // a stalled result word holds
   `MCID_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser),
      "stalled result changed")

endmodule

bind multi_channel_input_debouncer_top mcid_checker u_mcid_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

### tb/debounce_event_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// debounce_event_checker
// Watches the sample, result and register ports of the debouncer. It keeps
// its own per-channel stable level and countdown, predicts one event word
// per accepted sample and compares each accepted result word against the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module debounce_event_checker
   import mcid_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [REQ_DAT_W-1:0] req_tdata,   // [3:0] channel, [4] raw_level
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [RSP_DAT_W-1:0] rsp_tdata,   // [3:0] event_channel, [4] stable_level
   input  logic [RSP_USR_W-1:0] rsp_tuser,   // [1:0] event_kind
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   output int                   mismatches,
   output int                   outstanding,
   output int                   presses,
   output int                   releases
);

   typedef struct packed {
      chan_type chan;
      kind_type kind;
      logic     level;
   } debounce_event_type;

   // mirrored channel state and debounce times
   logic               stable_level [CHANNELS];
   count_type          countdown    [CHANNELS];
   count_type          debounce_time [0:CSR_KEY];
   debounce_event_type expected_events [$];

   int fail_total    = 0;
   int pending_total = 0;
   int press_total   = 0;
   int release_total = 0;

   assign mismatches  = fail_total;
   assign outstanding = pending_total;
   assign presses     = press_total;
   assign releases    = release_total;

   // pick the countdown load for a channel
   function automatic count_type load_for_channel(chan_type ch);
      case (ch)
         CH_POWER_A, CH_POWER_B: return debounce_time[CSR_POWER_BUTTON];
         CH_ADAPTER:             return debounce_time[CSR_ADAPTER];
         CH_BATTERY:             return debounce_time[CSR_BATTERY];
         CH_LID:                 return debounce_time[CSR_LID];
         default:                return debounce_time[CSR_KEY];
      endcase
   endfunction

   // advance one channel by one sample and return the event it produces
   function automatic debounce_event_type debounce_sample(chan_type ch, logic raw);
      debounce_event_type ev;
      ev.chan  = ch;
      ev.kind  = KIND_NONE;
      ev.level = 1'b0;
      // channels past the last line leave all state alone
      if (ch < CHANNELS) begin
         if (raw != stable_level[ch]) begin
            if (countdown[ch] == '0) begin
               countdown[ch] = load_for_channel(ch);
            end else begin
               countdown[ch] = countdown[ch] - 1'b1;
               if (countdown[ch] == '0) begin
                  stable_level[ch] = raw;
                  if (raw) begin
                     ev.kind = KIND_ASSERT;
                  end else begin
                     ev.kind = KIND_RELEASE;
                  end
               end
            end
         end else begin
            countdown[ch] = '0;
         end
         ev.level = stable_level[ch];
      end
      return ev;
   endfunction

   // track register writes, predict on sample words, compare on result words
   always @(posedge clock) begin : watch
      debounce_event_type want;
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            stable_level[i] = 1'b0;
            countdown[i]    = '0;
         end
         for (int i = 0; i <= CSR_KEY; i++) begin
            debounce_time[i] = '0;
         end
         expected_events.delete();
      end else begin
         if (csr_we && (csr_index <= CSR_KEY)) begin
            debounce_time[csr_index] = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            want = debounce_sample(req_tdata[CHAN_W-1:0], req_tdata[CHAN_W]);
            if (want.kind == KIND_ASSERT) press_total++;
            if (want.kind == KIND_RELEASE) release_total++;
            expected_events.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_events.size() == 0) begin
               fail_total++;
               $display("%0t: unexpected result word, expected none, got channel %0d kind %0d",
                        $time, rsp_tdata[CHAN_W-1:0], rsp_tuser);
            end else begin
               want = expected_events.pop_front();
               if (rsp_tdata[CHAN_W-1:0] !== want.chan) begin
                  fail_total++;
                  $display("%0t: event_channel expected %0d got %0d",
                           $time, want.chan, rsp_tdata[CHAN_W-1:0]);
               end
               if (rsp_tuser !== want.kind) begin
                  fail_total++;
                  $display("%0t: event_kind on channel %0d expected %0d got %0d",
                           $time, want.chan, want.kind, rsp_tuser);
               end
               if (rsp_tdata[CHAN_W] !== want.level) begin
                  fail_total++;
                  $display("%0t: stable_level on channel %0d expected %0d got %0d",
                           $time, want.chan, want.level, rsp_tdata[CHAN_W]);
               end
            end
         end
      end
      pending_total <= expected_events.size();
   end

endmodule

### tb/multi_channel_input_debouncer_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_channel_input_debouncer_top_tb
// Drives raw level samples into the debouncer under a series of debounce
// time settings: a short directed opening, then bursts of steady levels with
// bounces and stray samples mixed in, random idling on both sides and one
// long result stall. The checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module multi_channel_input_debouncer_top_tb
   import mcid_pkg::*;
();

   localparam int PHASES      = 8;
   localparam int HOLD_CYCLES = 64;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_DAT_W-1:0] req_tdata  = '0;   // [3:0] channel, [4] raw_level
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_DAT_W-1:0] rsp_tdata;         // [3:0] event_channel, [4] stable_level
   logic [RSP_USR_W-1:0] rsp_tuser;         // [1:0] event_kind
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [CSR_DAT_W-1:0] csr_wdata  = '0;

   int mismatches;
   int outstanding;
   int presses;
   int releases;

   // stimulus knobs shared with the result sink
   bit tx_idle      = 1'b1;
   bit rx_idle      = 1'b1;
   bit hold_request = 1'b0;
   bit hold_done    = 1'b0;
   int samples_sent = 0;
   count_type cur_time [0:CSR_KEY];

   multi_channel_input_debouncer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   debounce_event_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .presses     (presses),
      .releases    (releases)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // countdown load currently programmed for a channel, for burst sizing
   function automatic int load_of(chan_type ch);
      case (ch)
         CH_POWER_A, CH_POWER_B: return cur_time[CSR_POWER_BUTTON];
         CH_ADAPTER:             return cur_time[CSR_ADAPTER];
         CH_BATTERY:             return cur_time[CSR_BATTERY];
         CH_LID:                 return cur_time[CSR_LID];
         default:                return cur_time[CSR_KEY];
      endcase
   endfunction

   function automatic count_type pick_time(int lo, int hi);
      return count_type'($urandom_range(lo, hi));
   endfunction

   // offer one sample word, after a random gap if tx_idle, and hold it until taken
   task automatic send_sample(chan_type ch, logic raw);
      int gap;
      gap = tx_idle ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DAT_W-CHAN_W-1){1'b0}}, raw, ch};
      do @(posedge clock); while (!req_tready);
      samples_sent++;
   endtask

   // drop valid and wait until every predicted word has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic csr_put(logic [CSR_IDX_W-1:0] idx, count_type val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // write all five debounce times plus one stray write to an unused index
   task automatic program_times(count_type pb, count_type ad, count_type bt,
                                count_type ld, count_type ky);
      cur_time[CSR_POWER_BUTTON] = pb;
      cur_time[CSR_ADAPTER]      = ad;
      cur_time[CSR_BATTERY]      = bt;
      cur_time[CSR_LID]          = ld;
      cur_time[CSR_KEY]          = ky;
      csr_put(CSR_POWER_BUTTON, pb);
      csr_put(CSR_ADAPTER, ad);
      csr_put(CSR_BATTERY, bt);
      csr_put(CSR_LID, ld);
      csr_put(CSR_KEY, ky);
      csr_put(CSR_KEY + 3'($urandom_range(1, 3)), count_type'($urandom_range(0, 255)));
      csr_we <= 1'b0;
   endtask

   // bursts of a steady level on one channel, with bounces and stray words unless quiet
   task automatic run_phase(int budget, bit quiet);
      int sent_here;
      int len;
      int roll;
      chan_type ch;
      logic lvl;
      sent_here = 0;
      while (sent_here < budget) begin
         if (!quiet && ($urandom_range(0, 9) == 0)) begin
            send_sample(chan_type'($urandom_range(0, (1 << CHAN_W) - 1)),
                        1'($urandom_range(0, 1)));
            sent_here++;
         end else begin
            ch  = chan_type'($urandom_range(0, CHANNELS - 1));
            lvl = 1'($urandom_range(0, 1));
            if (quiet) begin
               len = load_of(ch) + $urandom_range(1, 3);
            end else begin
               len = $urandom_range(1, load_of(ch) + 3);
            end
            repeat (len) begin
               roll = quiet ? 2 : $urandom_range(0, 11);
               if (roll == 0) begin
                  send_sample(ch, ~lvl);
               end else if (roll == 1) begin
                  send_sample(chan_type'($urandom_range(0, (1 << CHAN_W) - 1)),
                              1'($urandom_range(0, 1)));
               end else begin
                  send_sample(ch, lvl);
               end
               sent_here++;
            end
         end
      end
   endtask

   // result side: random stalls, one long hold-off when asked
   initial begin : result_sink
      int stall;
      forever begin
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = rx_idle ? $urandom_range(0, 7) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   initial begin : stimulus
      int phase;
      int budget;
      bit quiet;
      count_type pb, ad, bt, ld, ky;

      for (int i = 0; i <= CSR_KEY; i++) cur_time[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // zero debounce time never fires; stray channels are ignored
      send_sample(CH_POWER_A, 1'b1);
      send_sample(CH_POWER_A, 1'b1);
      send_sample(chan_type'(CHANNELS - 1), 1'b1);
      send_sample(chan_type'((1 << CHAN_W) - 1), 1'b1);
      send_sample(chan_type'(CHANNELS), 1'b0);
      drain_results();

      // short times: press, release, match clearing a countdown
      program_times(8'd1, 8'd2, 8'd3, 8'd1, 8'd2);
      send_sample(CH_POWER_B, 1'b1);
      send_sample(CH_POWER_B, 1'b1);
      send_sample(CH_POWER_B, 1'b0);
      send_sample(CH_POWER_B, 1'b0);
      send_sample(CH_ADAPTER, 1'b1);
      send_sample(CH_ADAPTER, 1'b0);
      repeat (3) send_sample(CH_ADAPTER, 1'b1);
      repeat (3) send_sample(chan_type'(CHANNELS - 1), 1'b1);
      send_sample(CH_LID, 1'b1);
      send_sample(chan_type'(CHANNELS + 2), 1'b1);
      drain_results();

      for (phase = 0; phase < PHASES; phase++) begin
         tx_idle = 1'b1;
         rx_idle = 1'b1;
         quiet   = 1'b0;
         budget  = 200;
         pb = pick_time(1, 6);
         ad = pick_time(1, 6);
         bt = pick_time(1, 6);
         ld = pick_time(1, 6);
         ky = pick_time(1, 6);
         case (phase)
            0: begin
               pb = pick_time(1, 4);
               ad = pick_time(1, 4);
               bt = pick_time(1, 4);
               ld = pick_time(1, 4);
               ky = pick_time(1, 4);
               budget = 180;
            end
            1: begin
               // shortest nonzero times, full rate, with the long result stall
               {pb, ad, bt, ld, ky} = {5{8'd1}};
               tx_idle      = 1'b0;
               rx_idle      = 1'b0;
               hold_request = 1'b1;
               budget       = 150;
            end
            2: begin
               {pb, ad, bt, ld, ky} = {5{8'd0}};
               budget = 80;
            end
            3: begin
               // longest time on the power lines and battery, long clean bursts
               pb = 8'd255;
               ad = 8'd2;
               bt = 8'd255;
               ld = 8'd1;
               ky = 8'd3;
               quiet   = 1'b1;
               tx_idle = 1'b0;
               rx_idle = 1'b0;
               budget  = 500;
            end
            4: begin
               pb = pick_time(0, 255);
               ad = pick_time(0, 255);
               bt = pick_time(0, 255);
               ld = pick_time(0, 255);
               ky = pick_time(0, 255);
               budget = 150;
            end
            5: rx_idle = 1'b0;
            6: tx_idle = 1'b0;
            default: begin
               pb = pick_time(0, 3);
               ad = pick_time(0, 3);
               bt = pick_time(0, 3);
               ld = pick_time(0, 3);
               ky = pick_time(0, 3);
               budget = 350;
            end
         endcase
         program_times(pb, ad, bt, ld, ky);
         run_phase(budget, quiet);
         drain_results();
      end

      // let the pipeline settle before the verdict
      repeat (8) @(posedge clock);
      $display("covered %0d samples over %0d debounce settings, idle and stalls mixed",
               samples_sent, PHASES + 2);
      $display("predicted %0d press and %0d release events", presses, releases);
      if (mismatches == 0) begin
         $display("multi_channel_input_debouncer_top_tb: done, clean");
      end else begin
         $display("multi_channel_input_debouncer_top_tb: done, errors");
      end
      $finish;
   end

   // watchdog
   initial begin
      #1_000_000;
      $display("multi_channel_input_debouncer_top_tb: done, errors");
      $finish;
   end

endmodule
